>>> design/ppcp_pkg.sv
// shared types, constants and saturating helpers for the closest point core
package ppcp_pkg;

   localparam logic signed [63:0] SAT_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SAT_LO = -64'sh7FFF_FFFF_FFFF_FFFF;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] CSR_PATH_LENGTH    = 2'd0;
   localparam logic [1:0] CSR_STOP_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_ITER_LIMIT     = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_SQ_W,
      ST_D1_S,
      ST_D1_W,
      ST_D2_S,
      ST_D2_W,
      ST_NT_CHK,
      ST_G_S,
      ST_G_W,
      ST_H_S,
      ST_H_W,
      ST_NT_EVAL,
      ST_DIV_W,
      ST_DONE
   } state_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] q16_to_q32(input logic signed [31:0] v);
      return {{16{v[31]}}, v, 16'h0000};
   endfunction

   function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] sum;
      logic signed [63:0] r;
      sum = {a[63], a} + {b[63], b};
      if (!sum[64] && sum[63]) begin
         r = SAT_HI;
      end else if (sum[64] && (sum[63:0] <= 64'h8000_0000_0000_0000)) begin
         r = SAT_LO;
      end else begin
         r = sum[63:0];
      end
      return r;
   endfunction

endpackage

>>> design/ppcp_mul.sv
// saturating q32.32 multiplier built from four 32x32 partial products
module ppcp_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic               done,
   output logic signed [63:0] result
);

   logic        busy_ff;
   logic        done_ff;
   logic [2:0]  cnt_ff;
   logic [63:0] ma_ff;
   logic [63:0] mb_ff;
   logic        neg_ff;
   logic [63:0] pp_ff;
   logic [1:0]  sh_ff;
   logic [127:0] acc_ff;
   logic signed [63:0] res_ff;

   logic [31:0]  half_a;
   logic [31:0]  half_b;
   logic [127:0] pp_shifted;
   logic [127:0] rounded;
   logic         sat;
   logic [63:0]  mag_r;
   logic signed [63:0] fin;

   always_comb begin
      half_a = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      half_b = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      case (sh_ff)
         2'd0:    pp_shifted = {64'h0, pp_ff};
         2'd3:    pp_shifted = {pp_ff, 64'h0};
         default: pp_shifted = {32'h0, pp_ff, 32'h0};
      endcase
      rounded = acc_ff + 128'h8000_0000;
      sat     = |rounded[127:95];
      mag_r   = sat ? 64'(ppcp_pkg::SAT_HI) : {1'b0, rounded[94:32]};
      fin     = neg_ff ? -$signed(mag_r) : $signed(mag_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ma_ff  <= ppcp_pkg::mag64(a);
         mb_ff  <= ppcp_pkg::mag64(b);
         neg_ff <= a[63] ^ b[63];
         acc_ff <= 128'h0;
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff <= half_a * half_b;
            sh_ff <= cnt_ff[1:0];
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_ff <= acc_ff + pp_shifted;
         end
         if (cnt_ff == 3'd5) begin
            res_ff <= fin;
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> design/ppcp_div.sv
// radix-2 restoring divider giving |num| * 2^32 / |den|, saturated
module ppcp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [6:0]  cnt_ff;
   logic [95:0] nsh_ff;
   logic [63:0] den_ff;
   logic [63:0] rem_ff;
   logic [62:0] q_ff;
   logic        over_ff;
   logic [63:0] res_ff;

   logic [63:0] rem_sh;
   logic [62:0] q_sh;
   logic        fits;
   logic [63:0] rem_n;
   logic [62:0] q_n;
   logic        over_n;

   always_comb begin
      rem_sh = {rem_ff[62:0], nsh_ff[95]};
      q_sh   = {q_ff[61:0], 1'b0};
      over_n = over_ff | q_ff[62];
      fits   = rem_sh >= den_ff;
      rem_n  = fits ? rem_sh - den_ff : rem_sh;
      q_n    = fits ? (q_sh | 63'd1) : q_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'd95;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         nsh_ff  <= {num, 32'h0};
         den_ff  <= den;
         rem_ff  <= 64'h0;
         q_ff    <= 63'h0;
         over_ff <= 1'b0;
      end else if (busy_ff) begin
         nsh_ff  <= {nsh_ff[94:0], 1'b0};
         rem_ff  <= rem_n;
         q_ff    <= q_n;
         over_ff <= over_n;
         if (cnt_ff == 7'd0) begin
            res_ff <= over_n ? 64'(ppcp_pkg::SAT_HI) : {1'b0, q_n};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

>>> design/poly_path_closest_point_core.sv
// closest point on a polynomial path: coefficient store, sequencer and newton loop
// loads are taken only while idle; a query needs 2*(MAX_ORDER+1)^2 + 4*MAX_ORDER - 1
// multiplies to set up, then per newton step 4*MAX_ORDER - 3 multiplies and a divide,
// all on the shared four-pass multiplier and the bit-serial divider
// synchronous reset clears the coefficient stores and loads register defaults
module poly_path_closest_point_core #(
   parameter int MAX_ORDER = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic               req_axis,
   input  logic [2:0]         req_coeff_index,
   input  logic signed [31:0] req_coeff_value,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [30:0]        rsp_closest_s,
   output logic [7:0]         rsp_iterations_used,
   output logic               rsp_converged,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int NCOEF = MAX_ORDER + 1;
   localparam int NSQ   = 2 * MAX_ORDER + 1;
   localparam int IW    = $clog2(NCOEF);
   localparam int KW    = $clog2(NSQ);
   localparam bit H_ONE = (NSQ == 3);

   ppcp_pkg::state_type state_ff, state_in;

   logic signed [31:0] x_store_ff [NCOEF];
   logic signed [31:0] y_store_ff [NCOEF];
   logic signed [63:0] sq_ff [NSQ];
   logic signed [63:0] d1_ff [NSQ-1];
   logic signed [63:0] d2_ff [NSQ-2];

   logic [IW-1:0]      i_ff;
   logic [KW-1:0]      k_ff;
   logic               axis_ff;
   logic signed [31:0] px_ff;
   logic signed [31:0] py_ff;
   logic signed [63:0] ea_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] g_ff;
   logic signed [63:0] s_ff;
   logic [7:0]         iters_ff;
   logic               conv_ff;
   logic [30:0]        path_length_ff;
   logic [15:0]        thr_ff;
   logic [7:0]         limit_ff;
   logic               rsp_valid_ff;
   logic [30:0]        rsp_s_ff;
   logic [7:0]         rsp_iters_ff;
   logic               rsp_conv_ff;

   logic               req_fire;
   logic [KW:0]        j_ext;
   logic               pair_ok;
   logic [IW-1:0]      rd_idx;
   logic signed [31:0] coef_rd;
   logic signed [31:0] pos_rd;
   logic signed [63:0] e_rd;
   logic               last_i;
   logic               last_k;
   logic               sq_adv;
   logic [KW-1:0]      kp1;
   logic [63:0]        kconst;
   logic [IW+2:0]      cidx;
   logic               mul_start;
   logic signed [63:0] mul_a;
   logic signed [63:0] mul_b;
   logic               mul_done;
   logic signed [63:0] mul_res;
   logic               div_start;
   logic               div_done;
   logic [63:0]        div_res;
   logic signed [63:0] upper64;
   logic [63:0]        thr64;
   logic signed [63:0] delta;
   logic signed [63:0] s_sum;
   logic signed [63:0] s_clamp;
   logic               out_load;

   assign req_fire = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign upper64 = {17'h0, path_length_ff, 16'h0};
   assign thr64   = {32'h0, thr_ff, 16'h0};
   assign cidx    = {IW'(0), req_coeff_index};

   always_comb begin
      j_ext   = {1'b0, k_ff} - (KW+1)'(i_ff);
      pair_ok = !j_ext[KW] && (j_ext <= (KW+1)'(MAX_ORDER));
      rd_idx  = (state_ff == ppcp_pkg::ST_SQ_B) ? j_ext[IW-1:0] : i_ff;
      coef_rd = axis_ff ? y_store_ff[rd_idx] : x_store_ff[rd_idx];
      pos_rd  = axis_ff ? py_ff : px_ff;
      e_rd    = ppcp_pkg::q16_to_q32(coef_rd)
                - ((rd_idx == IW'(0)) ? ppcp_pkg::q16_to_q32(pos_rd) : 64'sh0);
      last_i  = (i_ff == IW'(NCOEF - 1));
      last_k  = (k_ff == KW'(NSQ - 1));
      kp1     = k_ff + KW'(1);
      kconst  = {(32-KW)'(0), kp1, 32'h0};
      delta   = (g_ff[63] == acc_ff[63]) ? -$signed(div_res) : $signed(div_res);
      s_sum   = ppcp_pkg::add_sat(s_ff, delta);
      if (s_sum[63]) begin
         s_clamp = 64'sh0;
      end else if (s_sum > upper64) begin
         s_clamp = upper64;
      end else begin
         s_clamp = s_sum;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppcp_pkg::ST_IDLE: begin
            if (req_fire && req_op == ppcp_pkg::OP_QUERY) state_in = ppcp_pkg::ST_SQ_A;
         end
         ppcp_pkg::ST_SQ_A: begin
            if (pair_ok) state_in = ppcp_pkg::ST_SQ_B;
            else if (last_i && last_k && axis_ff) state_in = ppcp_pkg::ST_D1_S;
         end
         ppcp_pkg::ST_SQ_B: state_in = ppcp_pkg::ST_SQ_W;
         ppcp_pkg::ST_SQ_W: begin
            if (mul_done) begin
               state_in = (last_i && last_k && axis_ff) ? ppcp_pkg::ST_D1_S
                                                        : ppcp_pkg::ST_SQ_A;
            end
         end
         ppcp_pkg::ST_D1_S: state_in = ppcp_pkg::ST_D1_W;
         ppcp_pkg::ST_D1_W: begin
            if (mul_done) begin
               state_in = (k_ff == KW'(NSQ - 2)) ? ppcp_pkg::ST_D2_S : ppcp_pkg::ST_D1_S;
            end
         end
         ppcp_pkg::ST_D2_S: state_in = ppcp_pkg::ST_D2_W;
         ppcp_pkg::ST_D2_W: begin
            if (mul_done) begin
               state_in = (k_ff == KW'(NSQ - 3)) ? ppcp_pkg::ST_NT_CHK : ppcp_pkg::ST_D2_S;
            end
         end
         ppcp_pkg::ST_NT_CHK: begin
            state_in = (conv_ff || iters_ff >= limit_ff) ? ppcp_pkg::ST_DONE
                                                         : ppcp_pkg::ST_G_S;
         end
         ppcp_pkg::ST_G_S: state_in = ppcp_pkg::ST_G_W;
         ppcp_pkg::ST_G_W: begin
            if (mul_done) begin
               if (k_ff == KW'(0)) begin
                  state_in = H_ONE ? ppcp_pkg::ST_NT_EVAL : ppcp_pkg::ST_H_S;
               end else begin
                  state_in = ppcp_pkg::ST_G_S;
               end
            end
         end
         ppcp_pkg::ST_H_S: state_in = ppcp_pkg::ST_H_W;
         ppcp_pkg::ST_H_W: begin
            if (mul_done) begin
               state_in = (k_ff == KW'(0)) ? ppcp_pkg::ST_NT_EVAL : ppcp_pkg::ST_H_S;
            end
         end
         ppcp_pkg::ST_NT_EVAL: begin
            state_in = (acc_ff == 64'sh0) ? ppcp_pkg::ST_NT_CHK : ppcp_pkg::ST_DIV_W;
         end
         ppcp_pkg::ST_DIV_W: begin
            if (div_done) state_in = ppcp_pkg::ST_NT_CHK;
         end
         ppcp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ppcp_pkg::ST_IDLE;
         end
         default: state_in = ppcp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      mul_start = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      mul_a     = 64'sh0;
      mul_b     = 64'sh0;
      sq_adv    = 1'b0;
      unique case (state_ff)
         ppcp_pkg::ST_IDLE: req_stall = 1'b0;
         ppcp_pkg::ST_SQ_A: sq_adv = !pair_ok;
         ppcp_pkg::ST_SQ_B: begin
            mul_start = 1'b1;
            mul_a     = ea_ff;
            mul_b     = e_rd;
         end
         ppcp_pkg::ST_SQ_W: sq_adv = mul_done;
         ppcp_pkg::ST_D1_S: begin
            mul_start = 1'b1;
            mul_a     = sq_ff[kp1];
            mul_b     = kconst;
         end
         ppcp_pkg::ST_D2_S: begin
            mul_start = 1'b1;
            mul_a     = d1_ff[kp1];
            mul_b     = kconst;
         end
         ppcp_pkg::ST_G_S, ppcp_pkg::ST_H_S: begin
            mul_start = 1'b1;
            mul_a     = acc_ff;
            mul_b     = s_ff;
         end
         ppcp_pkg::ST_NT_EVAL: div_start = (acc_ff != 64'sh0);
         ppcp_pkg::ST_DONE: out_load = !rsp_valid_ff || !rsp_stall;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ppcp_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         path_length_ff <= 31'd0;
         thr_ff         <= 16'd66;
         limit_ff       <= 8'd100;
         for (int n = 0; n < NCOEF; n++) begin
            x_store_ff[n] <= 32'sh0;
            y_store_ff[n] <= 32'sh0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= out_load || (rsp_valid_ff && rsp_stall);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ppcp_pkg::CSR_PATH_LENGTH:    path_length_ff <= csr_data[30:0];
               ppcp_pkg::CSR_STOP_THRESHOLD: thr_ff <= csr_data[15:0];
               ppcp_pkg::CSR_ITER_LIMIT:     limit_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
         if (req_fire && req_op == ppcp_pkg::OP_LOAD
             && cidx <= (IW+3)'(MAX_ORDER)) begin
            if (req_axis) y_store_ff[cidx[IW-1:0]] <= req_coeff_value;
            else x_store_ff[cidx[IW-1:0]] <= req_coeff_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_s_ff     <= s_ff[46:16];
         rsp_iters_ff <= iters_ff;
         rsp_conv_ff  <= conv_ff;
      end
      if (req_fire && req_op == ppcp_pkg::OP_QUERY) begin
         px_ff    <= req_pos_x;
         py_ff    <= req_pos_y;
         i_ff     <= IW'(0);
         k_ff     <= KW'(0);
         axis_ff  <= 1'b0;
         s_ff     <= 64'sh0;
         iters_ff <= 8'd0;
         conv_ff  <= 1'b0;
         for (int n = 0; n < NSQ; n++) sq_ff[n] <= 64'sh0;
      end
      if (state_ff == ppcp_pkg::ST_SQ_A && pair_ok) ea_ff <= e_rd;
      if (state_ff == ppcp_pkg::ST_SQ_W && mul_done) begin
         sq_ff[k_ff] <= ppcp_pkg::add_sat(sq_ff[k_ff], mul_res);
      end
      if (sq_adv) begin
         if (last_i) begin
            i_ff <= IW'(0);
            if (last_k) begin
               k_ff    <= KW'(0);
               axis_ff <= 1'b1;
            end else begin
               k_ff <= k_ff + KW'(1);
            end
         end else begin
            i_ff <= i_ff + IW'(1);
         end
      end
      if (state_ff == ppcp_pkg::ST_D1_W && mul_done) begin
         d1_ff[k_ff] <= mul_res;
         k_ff <= (k_ff == KW'(NSQ - 2)) ? KW'(0) : k_ff + KW'(1);
      end
      if (state_ff == ppcp_pkg::ST_D2_W && mul_done) begin
         d2_ff[k_ff] <= mul_res;
         k_ff <= k_ff + KW'(1);
      end
      if (state_ff == ppcp_pkg::ST_NT_CHK) begin
         acc_ff <= d1_ff[NSQ-2];
         k_ff   <= KW'(NSQ - 3);
      end
      if (state_ff == ppcp_pkg::ST_G_W && mul_done) begin
         if (k_ff == KW'(0)) begin
            g_ff   <= ppcp_pkg::add_sat(mul_res, d1_ff[k_ff]);
            acc_ff <= d2_ff[NSQ-3];
            k_ff   <= KW'(NSQ - 4);
         end else begin
            acc_ff <= ppcp_pkg::add_sat(mul_res, d1_ff[k_ff]);
            k_ff   <= k_ff - KW'(1);
         end
      end
      if (state_ff == ppcp_pkg::ST_H_W && mul_done) begin
         acc_ff <= ppcp_pkg::add_sat(mul_res, d2_ff[k_ff]);
         k_ff   <= k_ff - KW'(1);
      end
      if (state_ff == ppcp_pkg::ST_NT_EVAL && acc_ff == 64'sh0) begin
         iters_ff <= iters_ff + 8'd1;
         if (g_ff == 64'sh0) conv_ff <= 1'b1;
         else s_ff <= g_ff[63] ? upper64 : 64'sh0;
      end
      if (state_ff == ppcp_pkg::ST_DIV_W && div_done) begin
         s_ff     <= s_clamp;
         conv_ff  <= div_res < thr64;
         iters_ff <= iters_ff + 8'd1;
      end
   end

   ppcp_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   ppcp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (ppcp_pkg::mag64(g_ff)),
      .den      (ppcp_pkg::mag64(acc_ff)),
      .done     (div_done),
      .quotient (div_res)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_closest_s       = rsp_s_ff;
   assign rsp_iterations_used = rsp_iters_ff;
   assign rsp_converged       = rsp_conv_ff;

   a_s_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppcp_pkg::ST_DONE) |-> (!s_ff[63] && s_ff <= upper64))
      else $error("search point left its range");

   a_mul_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ppcp_pkg::ST_SQ_W || state_ff == ppcp_pkg::ST_D1_W
                    || state_ff == ppcp_pkg::ST_D2_W || state_ff == ppcp_pkg::ST_G_W
                    || state_ff == ppcp_pkg::ST_H_W))
      else $error("multiplier finished outside a wait state");

   a_iter_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ppcp_pkg::ST_DONE) |-> (iters_ff <= limit_ff))
      else $error("newton step count passed the limit");

endmodule
